[src/yrc_pkg.sv]
// ---------------------------------------------------------------------------
// yrc_pkg: shared types and constants for the 4:2:2 to RGB red pixel counter
// Holds field widths, the tally limit, register indexes and the lane result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yrc_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 10;
  localparam int TALLY_W = 23;
  localparam int INDEX_W = 2;

  // Largest frame the tally has to count, limited to what the tally holds
  localparam int MAX_FRAME_PIXELS = 4194304;
  localparam int TALLY_CAP        = (1 << TALLY_W) - 1;
  localparam logic [TALLY_W-1:0] TALLY_MAX =
    TALLY_W'((MAX_FRAME_PIXELS < TALLY_CAP) ? MAX_FRAME_PIXELS : TALLY_CAP);

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_RED_ABOVE   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_GREEN_BELOW = 2'd1;
  localparam logic [INDEX_W-1:0] REG_BLUE_BELOW  = 2'd2;

  // Threshold values after reset
  localparam logic signed [COLOR_W-1:0] RED_ABOVE_RST   = 10'sd100;
  localparam logic signed [COLOR_W-1:0] GREEN_BELOW_RST = 10'sd60;
  localparam logic signed [COLOR_W-1:0] BLUE_BELOW_RST  = 10'sd60;

  // One converted pixel and its red flag
  typedef struct packed {
    logic signed [COLOR_W-1:0] red;
    logic signed [COLOR_W-1:0] green;
    logic signed [COLOR_W-1:0] blue;
    logic                      is_red;
  } pix_rgb_t;

endpackage

`default_nettype wire

[src/yrc_lane.sv]
// ---------------------------------------------------------------------------
// yrc_lane: one pixel lane
// Converts one luma sample with the shared chroma pair to unclamped RGB by
// shift-add, tests the red thresholds and registers the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yrc_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         luma,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         u_byte,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         v_byte,
  input  wire logic signed [yrc_pkg::COLOR_W-1:0] red_above,
  input  wire logic signed [yrc_pkg::COLOR_W-1:0] green_below,
  input  wire logic signed [yrc_pkg::COLOR_W-1:0] blue_below,
  output yrc_pkg::pix_rgb_t                       pix
);
  import yrc_pkg::*;

  localparam int SUM_W = COLOR_W + 1;

  logic signed [BYTE_W-1:0] u_s;
  logic signed [BYTE_W-1:0] v_s;
  logic signed [SUM_W-1:0]  y_x;
  logic signed [SUM_W-1:0]  u_x;
  logic signed [SUM_W-1:0]  v_x;
  logic signed [SUM_W-1:0]  r_sum;
  logic signed [SUM_W-1:0]  g_sum;
  logic signed [SUM_W-1:0]  b_sum;
  logic                     red_hit;
  pix_rgb_t                 pix_next;

  // Re-center chroma: flipping the top bit subtracts 128
  assign u_s = {~u_byte[BYTE_W-1], u_byte[BYTE_W-2:0]};
  assign v_s = {~v_byte[BYTE_W-1], v_byte[BYTE_W-2:0]};
  assign y_x = {{(SUM_W-BYTE_W){1'b0}}, luma};
  assign u_x = SUM_W'(u_s);
  assign v_x = SUM_W'(v_s);

  // Shift-add color matrix, floor shifts
  assign r_sum = y_x + v_x + (v_x >>> 2) + (v_x >>> 3) + (v_x >>> 5);
  assign g_sum = y_x - ((u_x >>> 2) + (u_x >>> 4) + (u_x >>> 5))
                     - ((v_x >>> 1) + (v_x >>> 3) + (v_x >>> 4) + (v_x >>> 5));
  assign b_sum = y_x + u_x + (u_x >>> 1) + (u_x >>> 2) + (u_x >>> 6);

  // Red test against sign-extended thresholds
  assign red_hit = (r_sum > SUM_W'(red_above)) &&
                   (g_sum < SUM_W'(green_below)) &&
                   (b_sum < SUM_W'(blue_below));

  always_comb begin
    pix_next.red    = r_sum[COLOR_W-1:0];
    pix_next.green  = g_sum[COLOR_W-1:0];
    pix_next.blue   = b_sum[COLOR_W-1:0];
    pix_next.is_red = red_hit;
  end

  // Hold result until the next transfer into this stage
  always_ff @(posedge clk) begin
    if (load) begin
      pix <= pix_next;
    end
  end

endmodule

`default_nettype wire

[src/yrc_tally.sv]
// ---------------------------------------------------------------------------
// yrc_tally: merge stage
// Adds the red flags of both lanes to a saturating frame tally, clears it
// after the last pair of a frame and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yrc_tally (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s1_valid,
  input  wire logic                               s1_last,
  input  wire yrc_pkg::pix_rgb_t                  first,
  input  wire yrc_pkg::pix_rgb_t                  second,
  output logic                                    s2_ready,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [yrc_pkg::COLOR_W-1:0]      red_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      green_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      blue_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      red_second,
  output logic signed [yrc_pkg::COLOR_W-1:0]      green_second,
  output logic signed [yrc_pkg::COLOR_W-1:0]      blue_second,
  output logic                                    first_is_red,
  output logic                                    second_is_red,
  output logic [yrc_pkg::TALLY_W-1:0]             red_count,
  output logic                                    frame_done
);
  import yrc_pkg::*;

  logic [TALLY_W-1:0] tally;
  logic [TALLY_W:0]   sum;
  logic [TALLY_W-1:0] tally_sat;
  logic               load;

  // Output register frees up when empty or when its transfer completes
  assign s2_ready = !out_valid || !out_stall;
  assign load     = s1_valid && s2_ready;

  // Add both flags, stop at the limit
  assign sum = {1'b0, tally} + {{TALLY_W{1'b0}}, first.is_red}
                             + {{TALLY_W{1'b0}}, second.is_red};
  assign tally_sat = (sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : sum[TALLY_W-1:0];

  // Advance tally and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tally     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        tally     <= s1_last ? '0 : tally_sat;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (load) begin
      red_first     <= first.red;
      green_first   <= first.green;
      blue_first    <= first.blue;
      red_second    <= second.red;
      green_second  <= second.green;
      blue_second   <= second.blue;
      first_is_red  <= first.is_red;
      second_is_red <= second.is_red;
      red_count     <= tally_sat;
      frame_done    <= s1_last;
    end
  end

  // Tally never passes its limit
  a_tally_cap: assert property (@(posedge clk) disable iff (rst)
    tally <= TALLY_MAX)
    else $error("tally above limit");

  // Last pair of a frame clears the tally
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    load && s1_last |=> tally == '0)
    else $error("tally not cleared at frame end");

  // Within a frame the tally never drops
  a_tally_mono: assert property (@(posedge clk) disable iff (rst)
    load && !s1_last |=> tally >= $past(tally))
    else $error("tally dropped within frame");

  // Reported count matches the tally after a mid-frame transfer
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    load && !s1_last |=> red_count == tally)
    else $error("red_count differs from tally");

endmodule

`default_nettype wire

[src/yuv422_to_rgb_red_pixel_counter.sv]
// ---------------------------------------------------------------------------
// yuv422_to_rgb_red_pixel_counter: 4:2:2 to RGB with red pixel count
// Converts one packed U/Y1/V/Y2 group per transfer into two unclamped RGB
// pixels, flags red pixels and reports a saturating per-frame red count.
//
// Input channel: in_valid/in_stall with u_byte, luma_first, v_byte,
//   luma_second and last_in_frame. A transfer happens when in_valid is high
//   and in_stall is low.
// Output channel: out_valid/out_stall with both RGB pixels, their red flags,
//   red_count (red pixels of the frame up to and including this pair) and
//   frame_done (red_count is the frame total; the tally then restarts at 0).
// Registers: the pixel lane registers, then the tally merge stage with the
//   output register.
// Throughput: one pair per cycle while out_stall is low; both lanes and the
//   tally adder are combinational, so pairs stream back to back.
// Stall: when out_stall holds a full output register, the lane stage still
//   takes one more pair, then in_stall rises until the output drains.
// Reset: rst (synchronous) empties both stages, clears the tally and loads
//   the thresholds 100 / 60 / 60. Write thresholds only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yuv422_to_rgb_red_pixel_counter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration writes
  input  wire logic                               cfg_wr_en,
  input  wire logic [yrc_pkg::INDEX_W-1:0]        cfg_index,
  input  wire logic [yrc_pkg::COLOR_W-1:0]        cfg_data,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         u_byte,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         luma_first,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         v_byte,
  input  wire logic [yrc_pkg::BYTE_W-1:0]         luma_second,
  input  wire logic                               last_in_frame,
  // Output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [yrc_pkg::COLOR_W-1:0]      red_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      green_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      blue_first,
  output logic signed [yrc_pkg::COLOR_W-1:0]      red_second,
  output logic signed [yrc_pkg::COLOR_W-1:0]      green_second,
  output logic signed [yrc_pkg::COLOR_W-1:0]      blue_second,
  output logic                                    first_is_red,
  output logic                                    second_is_red,
  output logic [yrc_pkg::TALLY_W-1:0]             red_count,
  output logic                                    frame_done
);
  import yrc_pkg::*;

  logic signed [COLOR_W-1:0] red_above;
  logic signed [COLOR_W-1:0] green_below;
  logic signed [COLOR_W-1:0] blue_below;
  logic                      s1_valid;
  logic                      s1_last;
  logic                      s2_ready;
  logic                      accept;
  pix_rgb_t                  pix_first;
  pix_rgb_t                  pix_second;

  // Threshold registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      red_above   <= RED_ABOVE_RST;
      green_below <= GREEN_BELOW_RST;
      blue_below  <= BLUE_BELOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RED_ABOVE:   red_above   <= cfg_data;
        REG_GREEN_BELOW: green_below <= cfg_data;
        REG_BLUE_BELOW:  blue_below  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lane stage takes a pair when empty or when it moves on this cycle
  assign in_stall = s1_valid && !s2_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= last_in_frame;
    end
  end

  // Two lanes, one per pixel of the pair
  yrc_lane u_lane_first (
    .clk         (clk),
    .load        (accept),
    .luma        (luma_first),
    .u_byte      (u_byte),
    .v_byte      (v_byte),
    .red_above   (red_above),
    .green_below (green_below),
    .blue_below  (blue_below),
    .pix         (pix_first)
  );

  yrc_lane u_lane_second (
    .clk         (clk),
    .load        (accept),
    .luma        (luma_second),
    .u_byte      (u_byte),
    .v_byte      (v_byte),
    .red_above   (red_above),
    .green_below (green_below),
    .blue_below  (blue_below),
    .pix         (pix_second)
  );

  // Merge lane flags into the frame tally and drive the output
  yrc_tally u_tally (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_last       (s1_last),
    .first         (pix_first),
    .second        (pix_second),
    .s2_ready      (s2_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red_first     (red_first),
    .green_first   (green_first),
    .blue_first    (blue_first),
    .red_second    (red_second),
    .green_second  (green_second),
    .blue_second   (blue_second),
    .first_is_red  (first_is_red),
    .second_is_red (second_is_red),
    .red_count     (red_count),
    .frame_done    (frame_done)
  );

endmodule

`default_nettype wire

[dv/yuv422_to_rgb_red_pixel_counter_tb.sv]
// ---------------------------------------------------------------------------
// yuv422_to_rgb_red_pixel_counter_tb: self-checking bench for the red counter
// Streams 4:2:2 pairs through the block with bursty input and patterned
// output stalls. Predicts both RGB pixels, their red flags and the per-frame
// tally, and checks every output transfer in order. Thresholds are rewritten
// between phases, including out-of-range values and writes to the spare index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv422_to_rgb_red_pixel_counter_tb;
  import yrc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_PAIRS = 200;
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  // Everything one output transfer carries
  typedef struct packed {
    pix_rgb_t           first;
    pix_rgb_t           second;
    logic [TALLY_W-1:0] count;
    logic               done;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_wr_en = 1'b0;
  logic [INDEX_W-1:0]        cfg_index = '0;
  logic [COLOR_W-1:0]        cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [BYTE_W-1:0]         u_byte      = '0;
  logic [BYTE_W-1:0]         luma_first  = '0;
  logic [BYTE_W-1:0]         v_byte      = '0;
  logic [BYTE_W-1:0]         luma_second = '0;
  logic                      last_in_frame = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COLOR_W-1:0] red_first, green_first, blue_first;
  logic signed [COLOR_W-1:0] red_second, green_second, blue_second;
  logic                      first_is_red, second_is_red;
  logic [TALLY_W-1:0]        red_count;
  logic                      frame_done;

  // Predictor copy of the thresholds and the frame tally
  logic signed [COLOR_W-1:0] red_above_m   = RED_ABOVE_RST;
  logic signed [COLOR_W-1:0] green_below_m = GREEN_BELOW_RST;
  logic signed [COLOR_W-1:0] blue_below_m  = BLUE_BELOW_RST;
  logic [TALLY_W-1:0]        tally_m       = '0;
  pair_result_t              pending_results[$];

  int pairs_sent      = 0;
  int frames_sent     = 0;
  int settings_used   = 0;
  int results_checked = 0;
  int red_pixels_seen = 0;
  int mismatches      = 0;

  // Receiver stall control
  stall_mode_t      stall_mode    = STALL_NONE;
  int               mode_left     = 0;
  logic [7:0]       stall_pattern = 8'h00;
  int               hold_left     = 0;
  int               hold_asks     = 0;
  int               hold_seen     = 0;
  int               idle_cycles   = 0;

  yuv422_to_rgb_red_pixel_counter uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .u_byte(u_byte), .luma_first(luma_first), .v_byte(v_byte),
    .luma_second(luma_second), .last_in_frame(last_in_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_first(red_first), .green_first(green_first), .blue_first(blue_first),
    .red_second(red_second), .green_second(green_second),
    .blue_second(blue_second),
    .first_is_red(first_is_red), .second_is_red(second_is_red),
    .red_count(red_count), .frame_done(frame_done)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Convert one pixel with floor shifts and apply the red thresholds
  function automatic pix_rgb_t convert_pixel(input int y, input int u, input int v);
    pix_rgb_t p;
    int r, g, b;
    r = y + v + (v >>> 2) + (v >>> 3) + (v >>> 5);
    g = y - ((u >>> 2) + (u >>> 4) + (u >>> 5))
          - ((v >>> 1) + (v >>> 3) + (v >>> 4) + (v >>> 5));
    b = y + u + (u >>> 1) + (u >>> 2) + (u >>> 6);
    p.red    = COLOR_W'(r);
    p.green  = COLOR_W'(g);
    p.blue   = COLOR_W'(b);
    p.is_red = (r > int'(red_above_m)) && (g < int'(green_below_m)) &&
               (b < int'(blue_below_m));
    return p;
  endfunction

  // Work out one pair's result and advance the saturating frame tally
  function automatic pair_result_t convert_and_tally(input logic [7:0] u_b, y1, v_b, y2,
                                                     input logic last);
    pair_result_t res;
    int u, v;
    u = int'(u_b) - 128;
    v = int'(v_b) - 128;
    res.first  = convert_pixel(int'(y1), u, v);
    res.second = convert_pixel(int'(y2), u, v);
    if (res.first.is_red && tally_m < TALLY_MAX) tally_m = tally_m + 1'b1;
    if (res.second.is_red && tally_m < TALLY_MAX) tally_m = tally_m + 1'b1;
    res.count = tally_m;
    res.done  = last;
    if (last) tally_m = '0;
    return res;
  endfunction

  function automatic string format_result(input pair_result_t r);
    return $sformatf("R1 %0d G1 %0d B1 %0d R2 %0d G2 %0d B2 %0d red %b%b count %0d done %b",
                     $signed(r.first.red), $signed(r.first.green), $signed(r.first.blue),
                     $signed(r.second.red), $signed(r.second.green),
                     $signed(r.second.blue), r.first.is_red, r.second.is_red,
                     r.count, r.done);
  endfunction

  // Offer one pair and hold it until the transfer happens
  task automatic send_pair(input logic [7:0] u_b, y1, v_b, y2, input logic last);
    in_valid      <= 1'b1;
    u_byte        <= u_b;
    luma_first    <= y1;
    v_byte        <= v_b;
    luma_second   <= y2;
    last_in_frame <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(convert_and_tally(u_b, y1, v_b, y2, last));
    pairs_sent++;
    if (last) frames_sent++;
  endtask

  // One in four pairs leans toward red so the tally moves
  task automatic send_random_pair(input logic last);
    logic [7:0] u_b, y1, v_b, y2;
    if ($urandom_range(3) == 0) begin
      u_b = BYTE_W'($urandom_range(90));
      v_b = BYTE_W'($urandom_range(255, 160));
      y1  = BYTE_W'($urandom_range(140));
      y2  = BYTE_W'($urandom_range(140));
    end else begin
      u_b = BYTE_W'($urandom);
      v_b = BYTE_W'($urandom);
      y1  = BYTE_W'($urandom);
      y2  = BYTE_W'($urandom);
    end
    send_pair(u_b, y1, v_b, y2, last);
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three thresholds, then the spare index, which must be ignored
  task automatic set_thresholds(input int red_above, input int green_below,
                                input int blue_below);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_RED_ABOVE;
    cfg_data  <= COLOR_W'(red_above);
    @(posedge clk);
    cfg_index <= REG_GREEN_BELOW;
    cfg_data  <= COLOR_W'(green_below);
    @(posedge clk);
    cfg_index <= REG_BLUE_BELOW;
    cfg_data  <= COLOR_W'(blue_below);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= COLOR_W'($urandom);
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    red_above_m   = COLOR_W'(red_above);
    green_below_m = COLOR_W'(green_below);
    blue_below_m  = COLOR_W'(blue_below);
    settings_used++;
    @(posedge clk);
  endtask

  // Random frames in bursts of random length separated by random gaps
  task automatic run_random_phase(input int pair_total);
    int left, frame_left, burst;
    left       = pair_total;
    frame_left = $urandom_range(40, 1);
    while (left > 0) begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(16, 1);
      for (int k = 0; k < burst && left > 0; k++) begin
        frame_left--;
        send_random_pair(frame_left == 0);
        if (frame_left == 0) frame_left = $urandom_range(40, 1);
        left--;
      end
      pause_input(($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1));
    end
  endtask

  // Reset thresholds: byte extremes, neutral grey, strong chroma, frame ends
  task automatic test_directed_defaults();
    send_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    send_pair(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_pair(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_pair(8'h00, 8'h40, 8'hFF, 8'h10, 1'b1);
    send_pair(8'h40, 8'h20, 8'hF0, 8'h30, 1'b0);
    send_pair(8'h30, 8'h50, 8'hE0, 8'h5A, 1'b1);
  endtask

  // Threshold extremes, and values below the color range compared as written
  task automatic test_threshold_extremes();
    set_thresholds(-512, 511, 511);
    send_pair(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_pair(8'h80, 8'h7F, 8'h80, 8'h81, 1'b0);
    send_pair(8'h12, 8'hC4, 8'hE7, 8'h09, 1'b1);
    set_thresholds(511, -512, -512);
    send_pair(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    set_thresholds(-257, 100, 0);
    send_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pair(8'h10, 8'h30, 8'hC0, 8'h90, 1'b0);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'h20, 8'h05, 8'hFF, 8'h60, 1'b1);
  endtask

  // Phases of random traffic, each under its own threshold setting
  task automatic test_random_streams();
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        set_thresholds(int'(RED_ABOVE_RST), int'(GREEN_BELOW_RST), int'(BLUE_BELOW_RST));
      end else if ($urandom_range(3) == 0) begin
        set_thresholds(int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512,
                       int'($urandom_range(1023)) - 512);
      end else begin
        set_thresholds(int'($urandom_range(220)), int'($urandom_range(160)) - 40,
                       int'($urandom_range(160)) - 40);
      end
      run_random_phase(PHASE_PAIRS);
    end
  endtask

  // Long receiver hold-off while pairs keep coming, then a full drain
  task automatic test_output_holdoff();
    for (int rep = 0; rep < 2; rep++) begin
      drain();
      hold_asks++;
      for (int k = 0; k < 39; k++) send_random_pair($urandom_range(15) == 0);
      send_random_pair(1'b1);
      drain();
    end
  endtask

  // Receiver: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (mode_left == 0) begin
      stall_mode    <= stall_mode_t'($urandom_range(2));
      mode_left     <= $urandom_range(200, 20);
      stall_pattern <= 8'($urandom);
      out_stall     <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(2) == 0);
        end
        default: begin
          out_stall     <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // Compare each output transfer against the oldest prediction
  always @(posedge clk) begin : check_outputs
    pair_result_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen.first.red     = red_first;
      seen.first.green   = green_first;
      seen.first.blue    = blue_first;
      seen.first.is_red  = first_is_red;
      seen.second.red    = red_second;
      seen.second.green  = green_second;
      seen.second.blue   = blue_second;
      seen.second.is_red = second_is_red;
      seen.count         = red_count;
      seen.done          = frame_done;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no pair outstanding: %s", $time, format_result(seen));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        red_pixels_seen += int'(seen.first.is_red) + int'(seen.second.is_red);
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch on result %0d", $time, results_checked);
            $display("  expected %s", format_result(want));
            $display("  actual   %s", format_result(seen));
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_threshold_extremes();
    test_random_streams();
    test_output_holdoff();
    drain();
    repeat (16) @(posedge clk);
    $display("Streamed %0d pairs in %0d frames under %0d threshold settings",
             pairs_sent, frames_sent, settings_used);
    $display("Checked %0d results, %0d red pixels flagged, %0d mismatches",
             results_checked, red_pixels_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[yuv422_to_rgb_red_pixel_counter.f]
src/yrc_pkg.sv
src/yrc_lane.sv
src/yrc_tally.sv
src/yuv422_to_rgb_red_pixel_counter.sv
dv/yuv422_to_rgb_red_pixel_counter_tb.sv
